>>> rtl/core/c16fd_pkg.sv
// c16fd_pkg: shared types, constants and codes of the crc16 frame decoder
package c16fd_pkg;

	// longest payload accepted in the length field
	localparam int MAX_PAYLOAD = 512;
	// byte counter saturates one past the longest valid frame
	localparam int POS_CAP     = MAX_PAYLOAD + 16;
	localparam int POS_W       = $clog2(POS_CAP + 1);
	localparam int LEN_W       = 16;
	// compare width for position against length plus frame overhead
	localparam int CMP_W       = LEN_W + 1;

	// fixed frame layout
	localparam int HDR_BYTES      = 11;
	localparam int FRAME_OVERHEAD = 15;

	localparam logic [7:0]  SYNC_HI   = 8'hD3;
	localparam logic [7:0]  SYNC_LO   = 8'h91;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_MSB   = 16'h8000;
	localparam logic [9:0]  LEN_SAT   = 10'h3FF;

	// result item kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// end-of-frame status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PROTO = 2'd1;
	localparam logic [1:0] ST_CRC   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} c16fd_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_data;
		logic [8:0]  payload_offset;
		logic [1:0]  status;
		logic [7:0]  version;
		logic [7:0]  destination;
		logic [7:0]  source;
		logic [7:0]  command;
		logic [7:0]  flags;
		logic [15:0] sequence_res;
		logic [9:0]  payload_count;
	} c16fd_out_t;

endpackage

>>> rtl/core/c16fd_crc.sv
// c16fd_crc: one-byte update of the crc-16 (poly 1021, msb first)
module c16fd_crc (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);
	import c16fd_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

>>> rtl/core/c16fd_parse.sv
// c16fd_parse: frame position tracking, header capture, checks and result build
module c16fd_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc,
	input  c16fd_pkg::c16fd_in_t   in_item,
	output logic                   res_vld,
	output c16fd_pkg::c16fd_out_t  res_item
);
	import c16fd_pkg::*;

	localparam logic [POS_W-1:0] POS_SYNC_HI = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC_LO = POS_W'(1);
	localparam logic [POS_W-1:0] POS_VER     = POS_W'(2);
	localparam logic [POS_W-1:0] POS_DST     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SRC     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CMD     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_FLG     = POS_W'(6);
	localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(8);
	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(9);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(10);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0]      crc_q, crc_n, crc_upd;
	logic [7:0]       ver_q, ver_n, dst_q, dst_n, src_q, src_n;
	logic [7:0]       cmd_q, cmd_n, flg_q, flg_n;
	logic [15:0]      seq_q, seq_n, len_q, len_n, chk_q, chk_n;
	logic             fault_q, fault_n;

	logic [CMP_W-1:0] len_w, rel, cnt_w;
	logic             len_ok, is_payload, proto_bad;
	logic [7:0]       b;

	assign b = in_item.data_byte;

	c16fd_crc u_crc (
		.crc      (crc_q),
		.data     (b),
		.crc_next (crc_upd)
	);

	always_comb begin
		pos_n   = pos_q;
		crc_n   = crc_q;
		ver_n   = ver_q;
		dst_n   = dst_q;
		src_n   = src_q;
		cmd_n   = cmd_q;
		flg_n   = flg_q;
		seq_n   = seq_q;
		len_n   = len_q;
		chk_n   = chk_q;
		fault_n = fault_q;
		res_item   = '0;
		is_payload = 1'b0;
		proto_bad  = 1'b0;
		cnt_w      = '0;

		len_w  = CMP_W'(len_q);
		len_ok = (len_q <= LEN_W'(MAX_PAYLOAD));
		rel    = CMP_W'(pos_q) - CMP_W'(HDR_BYTES);

		priority if (pos_q == POS_SYNC_HI) begin
			if (b != SYNC_HI) fault_n = 1'b1;
		end else if (pos_q == POS_SYNC_LO) begin
			if (b != SYNC_LO) fault_n = 1'b1;
		end else if (pos_q <= POS_LEN_HI) begin
			crc_n = crc_upd;
			unique case (pos_q)
				POS_VER:    ver_n = b;
				POS_DST:    dst_n = b;
				POS_SRC:    src_n = b;
				POS_CMD:    cmd_n = b;
				POS_FLG:    flg_n = b;
				POS_SEQ_LO: seq_n = {seq_q[15:8], b};
				POS_SEQ_HI: seq_n = {b, seq_q[7:0]};
				POS_LEN_LO: len_n = {len_q[15:8], b};
				default: begin
					len_n = {b, len_q[7:0]};
					if ({b, len_q[7:0]} > LEN_W'(MAX_PAYLOAD)) fault_n = 1'b1;
				end
			endcase
		end else if (len_ok) begin
			// payload, then check bytes, then tail
			priority if (rel < len_w) begin
				crc_n      = crc_upd;
				is_payload = 1'b1;
				res_item.kind           = KIND_PAYLOAD;
				res_item.payload_data   = b;
				res_item.payload_offset = rel[8:0];
			end else if (rel == len_w) begin
				chk_n = {chk_q[15:8], b};
			end else if (rel == len_w + CMP_W'(1)) begin
				chk_n = {b, chk_q[7:0]};
			end else if (rel == len_w + CMP_W'(2)) begin
				if (b != SYNC_LO) fault_n = 1'b1;
			end else if (rel == len_w + CMP_W'(3)) begin
				if (b != SYNC_HI) fault_n = 1'b1;
			end else begin
				// bytes past the tail only advance the count
			end
		end else begin
			// oversized length: rest of the frame is only counted
		end

		pos_n = (pos_q < POS_W'(POS_CAP)) ? pos_q + POS_W'(1) : POS_W'(POS_CAP);

		if (in_item.last_byte) begin
			cnt_w     = CMP_W'(pos_n);
			proto_bad = fault_n || (len_n > LEN_W'(MAX_PAYLOAD))
				|| (cnt_w != CMP_W'(len_n) + CMP_W'(FRAME_OVERHEAD));
			res_item = '0;
			res_item.kind = KIND_STATUS;
			priority if (proto_bad) begin
				res_item.status = ST_PROTO;
			end else if (crc_n != chk_n) begin
				res_item.status = ST_CRC;
			end else begin
				res_item.status = ST_OK;
			end
			res_item.version        = ver_n;
			res_item.destination    = dst_n;
			res_item.source         = src_n;
			res_item.command        = cmd_n;
			res_item.flags          = flg_n;
			res_item.sequence_res   = seq_n;
			res_item.payload_count  = (len_n > 16'(LEN_SAT)) ? LEN_SAT : len_n[9:0];
			// frame done: back to reset values
			pos_n   = '0;
			crc_n   = CRC_INIT;
			ver_n   = '0;
			dst_n   = '0;
			src_n   = '0;
			cmd_n   = '0;
			flg_n   = '0;
			seq_n   = '0;
			len_n   = '0;
			chk_n   = '0;
			fault_n = 1'b0;
		end
	end

	assign res_vld = acc && (is_payload || in_item.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			crc_q   <= CRC_INIT;
			ver_q   <= '0;
			dst_q   <= '0;
			src_q   <= '0;
			cmd_q   <= '0;
			flg_q   <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			chk_q   <= '0;
			fault_q <= 1'b0;
		end else if (acc) begin
			pos_q   <= pos_n;
			crc_q   <= crc_n;
			ver_q   <= ver_n;
			dst_q   <= dst_n;
			src_q   <= src_n;
			cmd_q   <= cmd_n;
			flg_q   <= flg_n;
			seq_q   <= seq_n;
			len_q   <= len_n;
			chk_q   <= chk_n;
			fault_q <= fault_n;
		end
	end

endmodule

>>> rtl/core/c16fd_skid.sv
// c16fd_skid: result register with one skid entry
module c16fd_skid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_vld,
	input  c16fd_pkg::c16fd_out_t  res_item,
	output logic                   up_stall,
	output logic                   item_valid,
	output c16fd_pkg::c16fd_out_t  item_data,
	input  logic                   item_stall
);
	import c16fd_pkg::*;

	logic       out_vld_q, skid_vld_q;
	c16fd_out_t out_q, skid_q;
	logic       out_free;

	assign out_free   = !out_vld_q || !item_stall;
	assign up_stall   = skid_vld_q;
	assign item_valid = out_vld_q;
	assign item_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_vld;
			end
		end else if (res_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (res_vld) begin
				out_q <= res_item;
			end
		end else if (res_vld) begin
			skid_q <= res_item;
		end
	end

endmodule

>>> rtl/core/crc16_frame_decoder.sv
// crc16_frame_decoder: top level of the streaming crc-16 frame decoder
//
// byte channel (byte_valid, byte_stall, byte_data): one raw frame byte per
//   transfer, last_byte marks the final byte of a frame
// item channel (item_valid, item_stall, item_data): payload byte items as the
//   payload passes (kind 0), and one status item on the final byte (kind 1)
//   carrying ok, protocol error or crc error plus the captured header
// frame: d3 91, version, dst, src, cmd, flags, seq and length (16-bit little
//   endian), payload, crc-16 (poly 1021, init ffff) over header after sync and
//   payload, then tail 91 d3; protocol errors win over a crc mismatch
// result path: each result is registered, in the result register or the skid entry
// throughput: one byte per cycle while byte_stall is low, set by the one-byte crc
//   update and the decode that sit between the frame state and the result register
// stall: the result register has one skid entry behind it, so a byte is
//   still taken while a result waits; byte_stall rises only once that entry
//   is full, and a stalled result holds its value
// reset: arst_n clears the frame state and drops both result entries; the
//   frame state also returns to reset after every status item
module crc16_frame_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  c16fd_pkg::c16fd_in_t   byte_data,
	output logic                   item_valid,
	input  logic                   item_stall,
	output c16fd_pkg::c16fd_out_t  item_data
);
	import c16fd_pkg::*;

	logic       acc;
	logic       res_vld;
	c16fd_out_t res_item;

	// byte transfer
	assign acc = byte_valid && !byte_stall;

	// frame state, checks and result build
	c16fd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.in_item  (byte_data),
		.res_vld  (res_vld),
		.res_item (res_item)
	);

	// result register plus skid entry
	c16fd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_vld    (res_vld),
		.res_item   (res_item),
		.up_stall   (byte_stall),
		.item_valid (item_valid),
		.item_data  (item_data),
		.item_stall (item_stall)
	);

endmodule

>>> rtl/core/c16fd_checker.sv
// c16fd_checker: port-level assertions for the crc16 frame decoder, with bind
module c16fd_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   byte_valid,
	input logic                   byte_stall,
	input c16fd_pkg::c16fd_in_t   byte_data,
	input logic                   item_valid,
	input logic                   item_stall,
	input c16fd_pkg::c16fd_out_t  item_data
);
	import c16fd_pkg::*;

	// a stalled result stays and holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item_data))
		else $error("stalled result changed");

	// the byte side only stalls after the result side was stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> $past(item_valid && item_stall))
		else $error("byte_stall without a stalled result");

	// a new result appears only after a byte transfer
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_valid) |-> $past(byte_valid && !byte_stall))
		else $error("result without a byte transfer");

	// status items never carry payload fields, payload items never carry status
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> (item_data.kind == KIND_STATUS)
			? (item_data.payload_data == 8'h00 && item_data.payload_offset == 9'h000)
			: (item_data.status == ST_OK && item_data.payload_count == 10'h000))
		else $error("result fields do not match its kind");

endmodule

bind crc16_frame_decoder c16fd_checker u_c16fd_checker (.*);
